// ===== rtl/tabvm_pkg.sv =====
// ----------------------------------------------------------------------------
// tabvm_pkg
// Shared types, codes and decode helpers for the two-accumulator byte machine.
// ----------------------------------------------------------------------------
package tabvm_pkg;

  // Default memory size is 2**MEM_AW bytes; all addresses wrap at that size
  localparam int unsigned MEM_AW        = 16;
  localparam logic [63:0] START_ADDRESS = 64'd2048;

  // Operand shift register holds up to nine fetched bytes
  localparam int unsigned OPND_W = 72;
  localparam int unsigned CNT_W  = 4;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_EXEC  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_HALT  = 2'd1,
    MODE_FAULT = 2'd2
  } mode_e;

  // Opcodes
  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_LDA   = 8'd1;
  localparam logic [7:0] OP_STA   = 8'd2;
  localparam logic [7:0] OP_SWP   = 8'd3;
  localparam logic [7:0] OP_JMPA  = 8'd4;
  localparam logic [7:0] OP_JMPBZ = 8'd5;
  localparam logic [7:0] OP_ADDAB = 8'd6;
  localparam logic [7:0] OP_SUBAB = 8'd7;
  localparam logic [7:0] OP_LDAB  = 8'd8;
  localparam logic [7:0] OP_STAB  = 8'd9;
  localparam logic [7:0] OP_CMPAB = 8'd10;
  localparam logic [7:0] OP_VOID  = 8'd11;
  localparam logic [7:0] OP_LDPCA = 8'd12;

  // Memory port address source
  typedef enum logic [2:0] {
    ASEL_CLR,
    ASEL_REQ,
    ASEL_PC,
    ASEL_OPND,
    ASEL_BLANE
  } addr_sel_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] mem_address;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [1:0]  run_status;
    logic [63:0] program_counter;
    logic [63:0] accumulator_a;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      clr_step;
    logic      req_load;
    addr_sel_e addr_sel;
    logic      mem_we;
    logic      pc_inc;
    logic      op_pc_load;
    logic      opc_load;
    logic      opnd_shift;
    logic      rbyte_load;
    logic      alu_exec;
    logic      jump_exec;
    logic      lane_load;
    logic      out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic        clr_last;
    logic [1:0]  req_type;
    mode_e       mode;
    logic [7:0]  opcode;
    logic        lane_ok;
  } dp_status_t;

  // Number of operand bytes that follow an opcode
  function automatic logic [CNT_W-1:0] op_nbytes(input logic [7:0] op);
    logic [CNT_W-1:0] n;
    case (op)
      OP_LDA, OP_STA:    n = CNT_W'(9);
      OP_JMPBZ, OP_VOID: n = CNT_W'(8);
      OP_LDAB, OP_STAB:  n = CNT_W'(1);
      default:           n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/tabvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tabvm_ctrl
// Request sequencer: memory clear sweep, byte fetch loop and result handoff.
// ----------------------------------------------------------------------------
module tabvm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tabvm_pkg::ctrl_cmd_t   cmd_o,
  input  tabvm_pkg::dp_status_t  status_i
);
  import tabvm_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RDATA,
    ST_OPCODE,
    ST_DECODE,
    ST_FETCH,
    ST_LAST,
    ST_EXEC,
    ST_LOAD,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q;
  logic [CNT_W-1:0] nbytes;

  assign nbytes      = op_nbytes(status_i.opcode);
  assign out_valid_o = out_valid_q;

  // Decode state into commands and next state
  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ASEL_PC;
    in_ready_o     = 1'b0;
    state_d        = state_q;
    cnt_d          = cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ASEL_CLR;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status_i.req_type)
          REQ_WRITE: begin
            cmd_o.addr_sel = ASEL_REQ;
            cmd_o.mem_we   = 1'b1;
            state_d        = ST_DONE;
          end
          REQ_READ: begin
            cmd_o.addr_sel = ASEL_REQ;
            state_d        = ST_RDATA;
          end
          REQ_EXEC: begin
            if (status_i.mode == MODE_RUN) begin
              cmd_o.addr_sel   = ASEL_PC;
              cmd_o.pc_inc     = 1'b1;
              cmd_o.op_pc_load = 1'b1;
              state_d          = ST_OPCODE;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_RDATA: begin
        cmd_o.rbyte_load = 1'b1;
        state_d          = ST_DONE;
      end
      ST_OPCODE: begin
        cmd_o.opc_load = 1'b1;
        state_d        = ST_DECODE;
      end
      ST_DECODE: begin
        if (nbytes == '0) begin
          cmd_o.alu_exec = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cnt_d   = nbytes;
          state_d = ST_FETCH;
        end
      end
      // Issue one operand byte read per cycle, shift in the previous byte
      ST_FETCH: begin
        cmd_o.addr_sel   = ASEL_PC;
        cmd_o.pc_inc     = 1'b1;
        cmd_o.opnd_shift = 1'b1;
        cnt_d            = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        cmd_o.opnd_shift = 1'b1;
        state_d          = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (status_i.opcode)
          OP_LDA: begin
            cmd_o.addr_sel = ASEL_OPND;
            if (status_i.lane_ok) begin
              state_d = ST_LOAD;
            end
          end
          OP_LDAB: begin
            cmd_o.addr_sel = ASEL_BLANE;
            if (status_i.lane_ok) begin
              state_d = ST_LOAD;
            end
          end
          OP_STA: begin
            cmd_o.addr_sel = ASEL_OPND;
            cmd_o.mem_we   = status_i.lane_ok;
          end
          OP_STAB: begin
            cmd_o.addr_sel = ASEL_BLANE;
            cmd_o.mem_we   = status_i.lane_ok;
          end
          OP_JMPBZ: begin
            cmd_o.jump_exec = 1'b1;
          end
          default: begin
            cmd_o.jump_exec = 1'b0;
          end
        endcase
      end
      ST_LOAD: begin
        cmd_o.lane_load = 1'b1;
        state_d         = ST_DONE;
      end
      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, operand count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/tabvm_dp.sv =====
// ----------------------------------------------------------------------------
// tabvm_dp
// Datapath: byte memory, accumulators, program counter, operand register.
// ----------------------------------------------------------------------------
module tabvm_dp #(
  parameter int unsigned MemAw        = tabvm_pkg::MEM_AW,
  parameter logic [63:0] StartAddress = tabvm_pkg::START_ADDRESS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tabvm_pkg::in_item_t    in_data_i,
  input  tabvm_pkg::ctrl_cmd_t   cmd_i,
  output tabvm_pkg::dp_status_t  status_o,
  output tabvm_pkg::out_item_t   out_data_o
);
  import tabvm_pkg::*;

  localparam int unsigned MemDepth = 1 << MemAw;

  logic [7:0]        mem_q [MemDepth];
  logic [7:0]        rdata_q;
  logic [MemAw-1:0]  addr;
  logic [7:0]        wdata;
  logic [MemAw-1:0]  clr_q;

  logic [63:0]       acc_a_q, acc_a_d;
  logic [63:0]       acc_b_q, acc_b_d;
  logic [63:0]       pc_q, pc_d;
  mode_e             mode_q, mode_d;

  in_item_t          req_q;
  logic [63:0]       op_pc_q;
  logic [7:0]        opcode_q;
  logic [OPND_W-1:0] opnd_q;
  logic [7:0]        rbyte_q;
  out_item_t         out_q;

  logic [7:0]        lane_byte;
  logic [2:0]        lane_idx;
  logic [5:0]        lane_sh;
  logic              lane_ok;
  logic [63:0]       opnd_word;
  logic [63:0]       req_addr;
  logic [7:0]        a_lane;
  logic [63:0]       lane_mask;
  logic [64:0]       sub_w;

  // Lane and address operand sit at different ends for LDA and STA
  assign lane_byte = (opcode_q == OP_LDA) ? opnd_q[OPND_W-1:OPND_W-8] : opnd_q[7:0];
  assign opnd_word = (opcode_q == OP_STA) ? opnd_q[OPND_W-1:8] : opnd_q[63:0];
  assign lane_ok   = (lane_byte[4:3] == 2'b00);
  assign lane_idx  = lane_byte[2:0];
  assign lane_sh   = {lane_idx, 3'b000};
  assign a_lane    = 8'(acc_a_q >> lane_sh);
  assign lane_mask = ~(64'h0000_0000_0000_00FF << lane_sh);
  assign req_addr  = 64'(req_q.mem_address);
  assign sub_w     = {1'b0, acc_a_q} - {1'b0, acc_b_q};

  // Select memory address and write data
  always_comb begin
    unique case (cmd_i.addr_sel)
      ASEL_CLR:   addr = clr_q;
      ASEL_REQ:   addr = req_addr[MemAw-1:0];
      ASEL_PC:    addr = pc_q[MemAw-1:0];
      ASEL_OPND:  addr = opnd_word[MemAw-1:0];
      ASEL_BLANE: addr = acc_b_q[MemAw-1:0] + MemAw'(lane_idx);
      default:    addr = pc_q[MemAw-1:0];
    endcase
    unique case (cmd_i.addr_sel)
      ASEL_CLR: wdata = 8'h00;
      ASEL_REQ: wdata = req_q.write_byte;
      default:  wdata = a_lane;
    endcase
  end

  // Single-port byte memory with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[addr] <= wdata;
    end
    rdata_q <= mem_q[addr];
  end

  // Architectural state updates
  always_comb begin
    acc_a_d = acc_a_q;
    acc_b_d = acc_b_q;
    pc_d    = pc_q;
    mode_d  = mode_q;
    if (cmd_i.pc_inc) begin
      pc_d = pc_q + 64'd1;
    end
    if (cmd_i.jump_exec && (acc_b_q == 64'd0)) begin
      pc_d = opnd_word;
    end
    if (cmd_i.lane_load) begin
      acc_a_d = (acc_a_q & lane_mask) | (64'(rdata_q) << lane_sh);
    end
    if (cmd_i.alu_exec) begin
      case (opcode_q)
        OP_HALT:  mode_d = MODE_HALT;
        OP_SWP: begin
          acc_a_d = acc_b_q;
          acc_b_d = acc_a_q;
        end
        OP_JMPA:  pc_d    = acc_a_q;
        OP_ADDAB: acc_a_d = acc_a_q + acc_b_q;
        OP_SUBAB: acc_a_d = sub_w[64] ? 64'd0 : sub_w[63:0];
        OP_CMPAB: acc_b_d = (acc_a_q == acc_b_q) ? 64'd0 : 64'd1;
        OP_LDPCA: acc_a_d = op_pc_q;
        OP_LDA, OP_STA, OP_JMPBZ, OP_LDAB, OP_STAB, OP_VOID: begin
          mode_d = mode_q;
        end
        default:  mode_d = MODE_FAULT;
      endcase
    end
  end

  // Hold architectural state and clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_a_q <= '0;
      acc_b_q <= '0;
      pc_q    <= StartAddress;
      mode_q  <= MODE_RUN;
      clr_q   <= '0;
    end else begin
      acc_a_q <= acc_a_d;
      acc_b_q <= acc_b_d;
      pc_q    <= pc_d;
      mode_q  <= mode_d;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + MemAw'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_q   <= in_data_i;
      rbyte_q <= 8'h00;
    end
    if (cmd_i.rbyte_load) begin
      rbyte_q <= rdata_q;
    end
    if (cmd_i.op_pc_load) begin
      op_pc_q <= pc_q;
    end
    if (cmd_i.opc_load) begin
      opcode_q <= rdata_q;
    end
    if (cmd_i.opnd_shift) begin
      opnd_q <= {opnd_q[OPND_W-9:0], rdata_q};
    end
    if (cmd_i.out_load) begin
      out_q.read_byte       <= rbyte_q;
      out_q.run_status      <= mode_q;
      out_q.program_counter <= pc_q;
      out_q.accumulator_a   <= acc_a_q;
    end
  end

  assign status_o.clr_last = &clr_q;
  assign status_o.req_type = req_q.req_type;
  assign status_o.mode     = mode_q;
  assign status_o.opcode   = opcode_q;
  assign status_o.lane_ok  = lane_ok;
  assign out_data_o        = out_q;

endmodule

// ===== rtl/two_accumulator_byte_vm_core.sv =====
// ----------------------------------------------------------------------------
// two_accumulator_byte_vm_core
// Byte-memory machine with two 64-bit accumulators, one request per transfer.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 2**MemAw-byte memory to zero, one byte a
// cycle, and takes no request until the sweep is done. Each request is handled
// alone through the single memory port, one byte per cycle. A memory write
// goes from dispatch straight to done, a read adds a read-data step, and an
// execute request on a stopped machine goes straight to done. An instruction
// has an opcode and a decode step; without operands it executes at decode,
// else it adds a fetch step per operand byte, a last shift and an execute
// step, and LDA and LDAB add a load step for the data read when the lane is
// in range. The result is loaded into an output register in the cycle before
// the next request can be accepted, so the next request is taken while the
// result waits for the consumer; a later result holds in the block until the
// one before it has been transferred. Stopped machines (halt or invalid
// opcode) ignore execute requests until reset.
module two_accumulator_byte_vm_core #(
  parameter int unsigned MemAw        = tabvm_pkg::MEM_AW,
  parameter logic [63:0] StartAddress = tabvm_pkg::START_ADDRESS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tabvm_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tabvm_pkg::out_item_t out_data_o
);
  import tabvm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tabvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tabvm_dp #(
    .MemAw        (MemAw),
    .StartAddress (StartAddress)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  // A stopped machine stays stopped in the same mode
  a_sticky_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.mode != MODE_RUN) |=> (status.mode == $past(status.mode)))
    else $error("run mode left halt or fault");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  // No memory write while waiting for a request
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.mem_we)
    else $error("memory written while idle");

  // An accepted request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held after accepting a request");
`endif

endmodule
